>>> hw/rtl/stereo_biquad_lowpass_top_macros.svh
// Assertion macros for the stereo biquad low-pass block.
// Used by stereo_biquad_lowpass_top; no other dependencies.
`ifndef STEREO_BIQUAD_LOWPASS_TOP_MACROS_SVH
`define STEREO_BIQUAD_LOWPASS_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is high
`define SBQ_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high
`define SBQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hw/rtl/sbq_pkg.sv
// Shared types and constants for the stereo biquad low-pass block.
// No dependencies; used by every module in hw/rtl.
package sbq_pkg;

   localparam int SAMPLE_BITS    = 24;
   localparam int COEF_BITS      = 32;
   localparam int COEF_FRAC_BITS = 28;
   localparam int PROD_BITS      = COEF_BITS + SAMPLE_BITS;
   // five products summed, plus the rounding constant
   localparam int ACC_BITS       = PROD_BITS + 3;
   localparam int RND_BITS       = ACC_BITS - COEF_FRAC_BITS;
   localparam int ADDR_BITS      = 4;
   localparam int DATA_BITS      = 32;

   localparam logic signed [COEF_BITS-1:0] COEF_EVEN_RESET =
      COEF_BITS'(64'(1) << COEF_FRAC_BITS);
   localparam logic signed [ACC_BITS-1:0] ROUND_HALF =
      ACC_BITS'(64'(1) << (COEF_FRAC_BITS - 1));

   typedef enum logic [1:0] {
      REG_COEF_EVEN = 2'd0,
      REG_COEF_MID  = 2'd1,
      REG_COEF_FB1  = 2'd2,
      REG_COEF_FB2  = 2'd3
   } reg_index_type;

   typedef logic signed [SAMPLE_BITS-1:0] sample_type;
   typedef logic signed [COEF_BITS-1:0]   coef_word_type;

   typedef struct packed {
      coef_word_type even;
      coef_word_type mid;
      coef_word_type fb1;
      coef_word_type fb2;
   } coef_type;

   typedef struct packed {
      sample_type left_in;
      sample_type right_in;
   } req_type;

   typedef struct packed {
      sample_type left_out;
      sample_type right_out;
   } rsp_type;

endpackage

>>> hw/rtl/sbq_csr.sv
// Coefficient register file with an APB-style access port.
// Depends on sbq_pkg.
module sbq_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [sbq_pkg::ADDR_BITS-1:0]  paddr,
   input  logic [sbq_pkg::DATA_BITS-1:0]  pwdata,
   output logic [sbq_pkg::DATA_BITS-1:0]  prdata,
   output logic                           pready,
   output sbq_pkg::coef_type              coef
);

   sbq_pkg::coef_type      coef_ff;
   sbq_pkg::coef_type      coef_in;
   sbq_pkg::reg_index_type reg_index;
   logic                   wr_en;

   assign reg_index = sbq_pkg::reg_index_type'(paddr[sbq_pkg::ADDR_BITS-1:2]);
   assign wr_en     = psel & penable & pwrite;
   assign pready    = 1'b1;
   assign coef      = coef_ff;

   always_comb begin
      coef_in = coef_ff;
      if (wr_en) begin
         unique case (reg_index)
            sbq_pkg::REG_COEF_EVEN: coef_in.even = pwdata;
            sbq_pkg::REG_COEF_MID:  coef_in.mid  = pwdata;
            sbq_pkg::REG_COEF_FB1:  coef_in.fb1  = pwdata;
            sbq_pkg::REG_COEF_FB2:  coef_in.fb2  = pwdata;
         endcase
      end
   end

   always_comb begin
      unique case (reg_index)
         sbq_pkg::REG_COEF_EVEN: prdata = coef_ff.even;
         sbq_pkg::REG_COEF_MID:  prdata = coef_ff.mid;
         sbq_pkg::REG_COEF_FB1:  prdata = coef_ff.fb1;
         sbq_pkg::REG_COEF_FB2:  prdata = coef_ff.fb2;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff.even <= sbq_pkg::COEF_EVEN_RESET;
         coef_ff.mid  <= '0;
         coef_ff.fb1  <= '0;
         coef_ff.fb2  <= '0;
      end else begin
         coef_ff <= coef_in;
      end
   end

endmodule

>>> hw/rtl/sbq_chan.sv
// One channel of the direct form I biquad: sample history, five products,
// rounding and saturation. Depends on sbq_pkg.
module sbq_chan (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  sbq_pkg::coef_type     coef,
   input  sbq_pkg::sample_type   x,
   output sbq_pkg::sample_type   y
);

   sbq_pkg::sample_type x1_ff, x2_ff, y1_ff, y2_ff;
   sbq_pkg::sample_type x1_in, x2_in, y1_in, y2_in;

   logic signed [sbq_pkg::PROD_BITS-1:0] p_x, p_x1, p_x2, p_y1, p_y2;
   logic signed [sbq_pkg::ACC_BITS-1:0]  acc;
   logic signed [sbq_pkg::RND_BITS-1:0]  rnd;
   logic                                 in_range;

   assign p_x  = sbq_pkg::PROD_BITS'(coef.even) * sbq_pkg::PROD_BITS'(x);
   assign p_x1 = sbq_pkg::PROD_BITS'(coef.mid)  * sbq_pkg::PROD_BITS'(x1_ff);
   assign p_x2 = sbq_pkg::PROD_BITS'(coef.even) * sbq_pkg::PROD_BITS'(x2_ff);
   assign p_y1 = sbq_pkg::PROD_BITS'(coef.fb1)  * sbq_pkg::PROD_BITS'(y1_ff);
   assign p_y2 = sbq_pkg::PROD_BITS'(coef.fb2)  * sbq_pkg::PROD_BITS'(y2_ff);

   // exact sum plus half an LSB; dropping the fraction bits floors it
   assign acc = sbq_pkg::ACC_BITS'(p_x) + sbq_pkg::ACC_BITS'(p_x1)
              + sbq_pkg::ACC_BITS'(p_x2) - sbq_pkg::ACC_BITS'(p_y1)
              - sbq_pkg::ACC_BITS'(p_y2) + sbq_pkg::ROUND_HALF;
   assign rnd = acc[sbq_pkg::ACC_BITS-1:sbq_pkg::COEF_FRAC_BITS];

   // fits when every bit above the sample's sign bit matches it
   assign in_range = (rnd[sbq_pkg::RND_BITS-1:sbq_pkg::SAMPLE_BITS-1] == '0)
                  || (rnd[sbq_pkg::RND_BITS-1:sbq_pkg::SAMPLE_BITS-1] == '1);

   always_comb begin
      if (in_range) begin
         y = rnd[sbq_pkg::SAMPLE_BITS-1:0];
      end else if (rnd[sbq_pkg::RND_BITS-1]) begin
         y = {1'b1, {(sbq_pkg::SAMPLE_BITS-1){1'b0}}};
      end else begin
         y = {1'b0, {(sbq_pkg::SAMPLE_BITS-1){1'b1}}};
      end
   end

   assign x1_in = advance ? x     : x1_ff;
   assign x2_in = advance ? x1_ff : x2_ff;
   assign y1_in = advance ? y     : y1_ff;
   assign y2_in = advance ? y1_ff : y2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         x1_ff <= '0;
         x2_ff <= '0;
         y1_ff <= '0;
         y2_ff <= '0;
      end else begin
         x1_ff <= x1_in;
         x2_ff <= x2_in;
         y1_ff <= y1_in;
         y2_ff <= y2_in;
      end
   end

endmodule

>>> hw/rtl/stereo_biquad_lowpass_top.sv
// Stereo biquad low-pass filter: request/result pipeline and register port.
// Depends on sbq_pkg, sbq_csr, sbq_chan and stereo_biquad_lowpass_top_macros.svh.
//
// Takes one stereo pair per request and returns one filtered pair, one
// request per clock cycle sustained while the result side does not stall.
// A request goes into the input register at the edge it is accepted; the
// next edge that the result register is free writes the filtered pair there.
// Each channel's step (five 32x24 products, the sum, rounding and
// saturation) is combinational because the output feeds back into the next
// sample; that path sets the clock. Coefficients sit at byte addresses 0,
// 4, 8 and 12 in Q3.28; the user must write them only while the filter is
// idle, and the block itself does not enforce it.
`include "stereo_biquad_lowpass_top_macros.svh"

module stereo_biquad_lowpass_top (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  sbq_pkg::req_type              req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output sbq_pkg::rsp_type              rsp_data,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [sbq_pkg::ADDR_BITS-1:0] paddr,
   input  logic [sbq_pkg::DATA_BITS-1:0] pwdata,
   output logic [sbq_pkg::DATA_BITS-1:0] prdata,
   output logic                          pready
);

   sbq_pkg::coef_type   coef;
   sbq_pkg::sample_type y_left, y_right;

   logic             s1_valid_ff, s1_valid_in;
   sbq_pkg::req_type s1_data_ff, s1_data_in;
   logic             rsp_valid_ff, rsp_valid_in;
   sbq_pkg::rsp_type rsp_data_ff, rsp_data_in;
   logic             req_accept;
   logic             advance;
   logic             pipe_full;
   logic             rsp_drain;

   sbq_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .coef    (coef)
   );

   sbq_chan u_left (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .coef    (coef),
      .x       (s1_data_ff.left_in),
      .y       (y_left)
   );

   sbq_chan u_right (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .coef    (coef),
      .x       (s1_data_ff.right_in),
      .y       (y_right)
   );

   // the input register moves on whenever the result register is free
   assign advance    = s1_valid_ff & (~rsp_valid_ff | ~rsp_stall);
   assign req_stall  = s1_valid_ff & ~advance;
   assign req_accept = req_valid & ~req_stall;

   assign s1_valid_in  = req_accept | (s1_valid_ff & ~advance);
   assign s1_data_in   = req_accept ? req_data : s1_data_ff;
   assign rsp_valid_in = advance | (rsp_valid_ff & rsp_stall);

   assign pipe_full = s1_valid_ff & rsp_valid_ff & rsp_stall;
   assign rsp_drain = rsp_valid_ff & ~rsp_stall & ~advance;

   always_comb begin
      rsp_data_in = rsp_data_ff;
      if (advance) begin
         rsp_data_in.left_out  = y_left;
         rsp_data_in.right_out = y_right;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      s1_data_ff  <= s1_data_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `SBQ_ASSERT_NOW(a_stall_full, clock, reset, req_stall, pipe_full, "stall with room to spare")
   `SBQ_ASSERT_NEXT(a_adv_fills, clock, reset, advance, rsp_valid_ff, "request lost on advance")
   `SBQ_ASSERT_NEXT(a_rsp_drains, clock, reset, rsp_drain, !rsp_valid_ff, "taken result repeated")

endmodule

>>> verif/tb_top.sv
// Self-checking bench for stereo_biquad_lowpass_top: directed pairs, then random phases.
// Needs sbq_pkg and the RTL under hw/rtl; the expected pairs come from an in-bench filter model.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   typedef enum logic {
      ROW_PAIR,
      ROW_WRITE
   } row_kind_type;

   typedef struct packed {
      row_kind_type           kind;
      sbq_pkg::req_type       pair;
      logic                   typed;
      sbq_pkg::rsp_type       want;
      sbq_pkg::reg_index_type idx;
      sbq_pkg::coef_word_type val;
   } stim_row_type;

   localparam longint SAMPLE_MAX = (64'sd1 <<< (sbq_pkg::SAMPLE_BITS - 1)) - 1;
   localparam longint SAMPLE_MIN = -SAMPLE_MAX - 1;
   localparam sbq_pkg::sample_type S_MAX = sbq_pkg::sample_type'(SAMPLE_MAX);
   localparam sbq_pkg::sample_type S_MIN = sbq_pkg::sample_type'(SAMPLE_MIN);

   // second-order Butterworth low-pass, cutoff at a tenth of the sample rate
   localparam sbq_pkg::coef_word_type LP_B02 = 32'sd18107314;
   localparam sbq_pkg::coef_word_type LP_B1  = 32'sd36214628;
   localparam sbq_pkg::coef_word_type LP_A1  = -32'sd306805620;
   localparam sbq_pkg::coef_word_type LP_A2  = 32'sd110796734;

   localparam sbq_pkg::coef_word_type C_MAX = 32'sh7FFF_FFFF;
   localparam sbq_pkg::coef_word_type C_MIN = 32'sh8000_0000;
   localparam sbq_pkg::coef_word_type C_HALF = 32'sh0800_0000;

   localparam int PHASES = 7;
   localparam int PHASE_ITEMS = 120;
   localparam int HOLD_CYCLES = 80;
   localparam int SETTLE_CYCLES = 4;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_stall;
   sbq_pkg::req_type              req_data = '0;
   logic                          rsp_valid;
   logic                          rsp_stall = 1'b0;
   sbq_pkg::rsp_type              rsp_data;
   logic                          psel = 1'b0;
   logic                          penable = 1'b0;
   logic                          pwrite = 1'b0;
   logic [sbq_pkg::ADDR_BITS-1:0] paddr = '0;
   logic [sbq_pkg::DATA_BITS-1:0] pwdata = '0;
   logic [sbq_pkg::DATA_BITS-1:0] prdata;
   logic                          pready;

   stereo_biquad_lowpass_top dut (
      .clock   (clock),
      .reset   (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   // filter model: coefficient copy and per-channel history, 0 = left, 1 = right
   sbq_pkg::coef_word_type coef_even = sbq_pkg::COEF_EVEN_RESET;
   sbq_pkg::coef_word_type coef_mid = '0;
   sbq_pkg::coef_word_type coef_fb1 = '0;
   sbq_pkg::coef_word_type coef_fb2 = '0;
   sbq_pkg::sample_type    x_prev [2] = '{default: '0};
   sbq_pkg::sample_type    x_prev2 [2] = '{default: '0};
   sbq_pkg::sample_type    y_prev [2] = '{default: '0};
   sbq_pkg::sample_type    y_prev2 [2] = '{default: '0};

   sbq_pkg::rsp_type pending_pairs [$];
   stim_row_type     directed_rows [$];
   int               mismatches = 0;
   bit               sender_idling = 1'b1;
   bit               receiver_idling = 1'b1;
   bit               hold_req = 1'b0;

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #3_000_000;
      $display("tb: failure");
      $finish;
   end

   function automatic sbq_pkg::sample_type filter_step(int ch, sbq_pkg::sample_type x);
      longint acc;
      acc = longint'(coef_even) * longint'(x)
          + longint'(coef_mid) * longint'(x_prev[ch])
          + longint'(coef_even) * longint'(x_prev2[ch])
          - longint'(coef_fb1) * longint'(y_prev[ch])
          - longint'(coef_fb2) * longint'(y_prev2[ch]);
      // add half then floor: ties go towards plus infinity
      acc = (acc + (64'sd1 <<< (sbq_pkg::COEF_FRAC_BITS - 1))) >>> sbq_pkg::COEF_FRAC_BITS;
      if (acc > SAMPLE_MAX) begin
         acc = SAMPLE_MAX;
      end else if (acc < SAMPLE_MIN) begin
         acc = SAMPLE_MIN;
      end
      x_prev2[ch] = x_prev[ch];
      x_prev[ch]  = x;
      y_prev2[ch] = y_prev[ch];
      y_prev[ch]  = sbq_pkg::sample_type'(acc);
      return sbq_pkg::sample_type'(acc);
   endfunction

   function automatic sbq_pkg::rsp_type filter_pair(sbq_pkg::req_type r);
      sbq_pkg::rsp_type o;
      o.left_out  = filter_step(0, r.left_in);
      o.right_out = filter_step(1, r.right_in);
      return o;
   endfunction

   function automatic void log_fault(string msg);
      mismatches++;
      if (mismatches <= 10) begin
         $display("%s", msg);
      end
   endfunction

   function automatic sbq_pkg::sample_type rand_sample();
      case ($urandom_range(0, 7))
         0: return $urandom_range(0, 1) ? S_MAX : S_MIN;
         1, 2: return sbq_pkg::sample_type'($urandom_range(0, 64))
                      - sbq_pkg::sample_type'(32);
         default: return sbq_pkg::sample_type'($urandom());
      endcase
   endfunction

   function automatic sbq_pkg::coef_word_type rand_small_coef();
      // roughly within +/-1.0
      return sbq_pkg::coef_word_type'($urandom_range(0, 32'h2000_0000))
             - sbq_pkg::coef_word_type'(32'h1000_0000);
   endfunction

   function automatic void add_pair(sbq_pkg::sample_type l, sbq_pkg::sample_type r, bit typed,
                                    sbq_pkg::sample_type wl, sbq_pkg::sample_type wr);
      stim_row_type row;
      row = '0;
      row.kind = ROW_PAIR;
      row.pair = '{left_in: l, right_in: r};
      row.typed = typed;
      row.want = '{left_out: wl, right_out: wr};
      directed_rows.push_back(row);
   endfunction

   function automatic void add_write(sbq_pkg::reg_index_type idx, sbq_pkg::coef_word_type val);
      stim_row_type row;
      row = '0;
      row.kind = ROW_WRITE;
      row.idx = idx;
      row.val = val;
      directed_rows.push_back(row);
   endfunction

   // called at a rising edge; returns at the edge where the request is taken
   task automatic send_pair(sbq_pkg::req_type d, bit typed, sbq_pkg::rsp_type want);
      sbq_pkg::rsp_type predicted;
      if (sender_idling && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
      req_data  <= d;
      req_valid <= 1'b1;
      do @(posedge clock); while (!(req_valid && !req_stall));
      predicted = filter_pair(d);
      pending_pairs.push_back(typed ? want : predicted);
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending_pairs.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_coef(sbq_pkg::reg_index_type idx, sbq_pkg::coef_word_type val);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= val;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      case (idx)
         sbq_pkg::REG_COEF_EVEN: coef_even = val;
         sbq_pkg::REG_COEF_MID:  coef_mid = val;
         sbq_pkg::REG_COEF_FB1:  coef_fb1 = val;
         sbq_pkg::REG_COEF_FB2:  coef_fb2 = val;
      endcase
      // read back through the same port
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata !== val) begin
         log_fault($sformatf("readback %s: expected %h, got %h", idx.name(), val, prdata));
      end
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic load_coefs(sbq_pkg::coef_word_type e, sbq_pkg::coef_word_type m,
                             sbq_pkg::coef_word_type f1, sbq_pkg::coef_word_type f2);
      wait_idle();
      write_coef(sbq_pkg::REG_COEF_EVEN, e);
      write_coef(sbq_pkg::REG_COEF_MID, m);
      write_coef(sbq_pkg::REG_COEF_FB1, f1);
      write_coef(sbq_pkg::REG_COEF_FB2, f2);
   endtask

   // result side stalls: random bursts, or one long hold-off on request
   initial begin
      forever begin
         if (hold_req) begin
            hold_req = 1'b0;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else if (receiver_idling && $urandom_range(0, 7) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 17)) @(posedge clock);
         end else begin
            rsp_stall <= 1'b0;
            @(posedge clock);
         end
      end
   end

   initial begin
      sbq_pkg::rsp_type want;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            if (pending_pairs.size() == 0) begin
               log_fault($sformatf("unexpected result %0d/%0d",
                                   $signed(rsp_data.left_out), $signed(rsp_data.right_out)));
            end else begin
               want = pending_pairs.pop_front();
               if (rsp_data.left_out !== want.left_out) begin
                  log_fault($sformatf("left_out: expected %0d, got %0d",
                                      $signed(want.left_out), $signed(rsp_data.left_out)));
               end
               if (rsp_data.right_out !== want.right_out) begin
                  log_fault($sformatf("right_out: expected %0d, got %0d",
                                      $signed(want.right_out), $signed(rsp_data.right_out)));
               end
            end
         end
      end
   end

   initial begin
      sbq_pkg::req_type d;
      sbq_pkg::rsp_type none;
      none = '0;

      // reset coefficients: y = x + x2, so early outputs can be read straight off
      add_pair(S_MAX, S_MIN, 1'b1, S_MAX, S_MIN);
      add_pair('0, '0, 1'b1, '0, '0);
      add_pair(S_MAX, S_MIN, 1'b1, S_MAX, S_MIN);      // both channels saturate
      add_pair(24'sd1, -24'sd1, 1'b1, 24'sd1, -24'sd1);
      add_pair(S_MIN, S_MAX, 1'b1, -24'sd1, -24'sd1);
      add_pair('0, '0, 1'b1, 24'sd1, -24'sd1);
      // half gain: rounding of exact halves
      add_write(sbq_pkg::REG_COEF_EVEN, C_HALF);
      add_pair(24'sd1, -24'sd1, 1'b0, '0, '0);
      add_pair('0, '0, 1'b0, '0, '0);
      add_pair('0, '0, 1'b0, '0, '0);
      add_pair(24'sd1, -24'sd1, 1'b1, 24'sd1, '0);
      add_pair(24'sd3, -24'sd3, 1'b1, 24'sd2, -24'sd1);
      // coefficient extremes, feedback driven into saturation
      add_write(sbq_pkg::REG_COEF_MID, C_MIN);
      add_write(sbq_pkg::REG_COEF_FB1, C_MAX);
      add_write(sbq_pkg::REG_COEF_FB2, C_MIN);
      add_pair(S_MAX, S_MIN, 1'b0, '0, '0);
      add_pair(S_MIN, S_MAX, 1'b0, '0, '0);
      add_pair('0, '0, 1'b0, '0, '0);
      add_pair(24'sh555555, 24'shAAAAAA, 1'b0, '0, '0);
      add_pair(24'shAAAAAA, 24'sh555555, 1'b0, '0, '0);
      add_write(sbq_pkg::REG_COEF_EVEN, C_MAX);
      add_write(sbq_pkg::REG_COEF_MID, C_MAX);
      add_write(sbq_pkg::REG_COEF_FB1, C_MIN);
      add_write(sbq_pkg::REG_COEF_FB2, C_MAX);
      add_pair(24'sd1, -24'sd1, 1'b0, '0, '0);
      add_pair(S_MAX, S_MAX, 1'b0, '0, '0);
      add_pair(S_MIN, S_MIN, 1'b0, '0, '0);
      add_pair('0, '0, 1'b0, '0, '0);

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == ROW_WRITE) begin
            wait_idle();
            write_coef(directed_rows[i].idx, directed_rows[i].val);
         end else begin
            send_pair(directed_rows[i].pair, directed_rows[i].typed, directed_rows[i].want);
         end
      end

      for (int p = 0; p < PHASES; p++) begin
         if (p == PHASES - 1) begin
            sender_idling = 1'b0;
            receiver_idling = 1'b0;
         end
         case (p)
            0, 6: load_coefs(LP_B02, LP_B1, LP_A1, LP_A2);
            1, 4: load_coefs($urandom(), $urandom(), $urandom(), $urandom());
            3:    load_coefs(sbq_pkg::COEF_EVEN_RESET, rand_small_coef(), '0,
                             rand_small_coef());
            default: load_coefs(rand_small_coef(), rand_small_coef(),
                                rand_small_coef(), rand_small_coef());
         endcase
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            // result side holds off while requests keep coming, so the pipe backs up
            if (p == 2 && n == 30) begin
               hold_req = 1'b1;
            end
            if (p == 4 && n == 60) begin
               wait_idle();
            end
            d.left_in  = rand_sample();
            d.right_in = rand_sample();
            send_pair(d, 1'b0, none);
         end
      end

      wait_idle();
      if (mismatches == 0 && pending_pairs.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
